FILE: rtl/ipr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_pkg - shared types and codes of the IP range trigger table
// Request and result payloads, entry status codes, mode codes and the
// carry record that moves from cell to cell along the chain.
// ----------------------------------------------------------------------------
package ipr_pkg;

   localparam logic [2:0] MODE_LOOKUP  = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_CLEAR   = 3'd2;
   localparam logic [2:0] MODE_ARM     = 3'd3;
   localparam logic [2:0] MODE_DISARM  = 3'd4;
   localparam logic [2:0] MODE_QUERY   = 3'd5;

   // register index, taken from paddr[2]
   localparam logic REG_IDX_OWN_ADDRESS = 1'b0;

   localparam int TAG_WIDTH  = 16;
   localparam int ADDR_WIDTH = 32;

   typedef enum logic [1:0] {
      ST_OFF       = 2'd0,
      ST_ARMED     = 2'd1,
      ST_TRIGGERED = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]            mode;
      logic [ADDR_WIDTH-1:0] src_addr;
      logic [ADDR_WIDTH-1:0] dst_addr;
      logic [ADDR_WIDTH-1:0] src_low;
      logic [ADDR_WIDTH-1:0] src_high;
      logic [ADDR_WIDTH-1:0] dst_low;
      logic [ADDR_WIDTH-1:0] dst_high;
      logic [TAG_WIDTH-1:0]  tag;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic                 newly_triggered;
      logic                 query_found;
      logic [TAG_WIDTH-1:0] query_tag;
      logic                 add_rejected;
   } rsp_type;

   // state of one transfer as it walks the chain
   typedef struct packed {
      logic                 done;
      logic                 newly;
      logic [TAG_WIDTH-1:0] qtag;
   } carry_type;

endpackage
`default_nettype wire

FILE: rtl/ipr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_cell - one trigger entry of the chain
// Holds one entry and its status. When the token reaches it, applies the
// current command to its entry and hands token and carry to the next cell.
// ----------------------------------------------------------------------------
module ipr_cell
   import ipr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire req_type   cmd,
   input  wire logic      tok_in,
   input  wire carry_type carry_in,
   output logic           tok_out,
   output carry_type      carry_out
);

   logic                  used_ff, used_in;
   status_type            status_ff, status_in;
   logic [ADDR_WIDTH-1:0] src_low_ff, src_high_ff, dst_low_ff, dst_high_ff;
   logic [TAG_WIDTH-1:0]  tag_ff;
   logic                  load;
   logic                  tok_ff;
   carry_type             carry_ff, carry_in_c;
   logic                  in_range;
   logic                  tag_match;

   assign in_range = (cmd.src_addr >= src_low_ff) && (cmd.src_addr <= src_high_ff) &&
                     (cmd.dst_addr >= dst_low_ff) && (cmd.dst_addr <= dst_high_ff);
   assign tag_match = used_ff && (tag_ff == cmd.tag);

   always_comb begin
      used_in    = used_ff;
      status_in  = status_ff;
      load       = 1'b0;
      carry_in_c = carry_in;
      if (tok_in) begin
         unique case (cmd.mode)
            MODE_LOOKUP: begin
               if (!carry_in.done && used_ff && status_ff != ST_OFF && in_range) begin
                  carry_in_c.done = 1'b1;
                  if (status_ff == ST_ARMED) begin
                     status_in        = ST_TRIGGERED;
                     carry_in_c.newly = 1'b1;
                  end
               end
            end
            MODE_ADD: begin
               // first free cell takes the entry
               if (!carry_in.done && !used_ff) begin
                  load            = 1'b1;
                  used_in         = 1'b1;
                  status_in       = ST_ARMED;
                  carry_in_c.done = 1'b1;
               end
            end
            MODE_CLEAR: begin
               used_in   = 1'b0;
               status_in = ST_OFF;
            end
            MODE_ARM: begin
               if (tag_match) begin
                  status_in = ST_ARMED;
               end
            end
            MODE_DISARM: begin
               if (tag_match) begin
                  status_in = ST_OFF;
               end
            end
            MODE_QUERY: begin
               if (!carry_in.done && used_ff && status_ff == ST_TRIGGERED) begin
                  carry_in_c.done = 1'b1;
                  carry_in_c.qtag = tag_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         status_ff <= ST_OFF;
         tok_ff    <= 1'b0;
      end else begin
         used_ff   <= used_in;
         status_ff <= status_in;
         tok_ff    <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in_c;
      if (load) begin
         src_low_ff  <= cmd.src_low;
         src_high_ff <= cmd.src_high;
         dst_low_ff  <= cmd.dst_low;
         dst_high_ff <= cmd.dst_high;
         tag_ff      <= cmd.tag;
      end
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;

endmodule
`default_nettype wire

FILE: rtl/ip_range_trigger_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ip_range_trigger_table - range trigger table, top level
// A chain of ENTRIES entry cells with a command register and an APB-style
// register port for the bridge's own address.
// ----------------------------------------------------------------------------
// Each command (lookup, add, clear, arm, disarm, query) is taken when start
// is high and busy is low, and gives exactly one result: the command is
// registered and the token enters the first cell in the cycle after the
// transfer, walks one entry cell per cycle carrying the first-match state,
// and then rsp_strobe is high for one cycle. busy rises with the registered
// command and stays high through the strobe cycle, so a new command can start
// only once the last result is out. Results are shown for that single strobe
// cycle; the receiver must take them then.
// Entries are kept in insertion order, first free cell first; a lookup or
// query reports the lowest-order matching entry.
// ----------------------------------------------------------------------------
module ip_range_trigger_table
   import ipr_pkg::*;
#(
   parameter int ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic            busy_ff, busy_in;
   logic            go_ff;
   req_type         cmd_ff;
   logic            own_match_ff;
   logic [31:0]     own_addr_ff;
   logic            accept;
   logic            csr_write;
   logic            tok   [0:ENTRIES];
   carry_type       carry [0:ENTRIES];
   logic [ENTRIES-1:0] tok_vec;

   assign accept    = start && !busy_ff;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_IDX_OWN_ADDRESS) ? own_addr_ff : 32'd0;
   assign busy      = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok[ENTRIES]) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         go_ff       <= 1'b0;
         own_addr_ff <= 32'd0;
      end else begin
         busy_ff <= busy_in;
         go_ff   <= accept;
         if (csr_write && paddr[2] == REG_IDX_OWN_ADDRESS) begin
            own_addr_ff <= pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_data;
         own_match_ff <= (req_data.dst_addr == own_addr_ff);
      end
   end

   // a lookup to the bridge itself enters the chain already settled
   assign tok[0]         = go_ff;
   assign carry[0].done  = (cmd_ff.mode == MODE_LOOKUP) && own_match_ff;
   assign carry[0].newly = 1'b0;
   assign carry[0].qtag  = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ipr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd_ff),
         .tok_in    (tok[i]),
         .carry_in  (carry[i]),
         .tok_out   (tok[i+1]),
         .carry_out (carry[i+1])
      );
      assign tok_vec[i] = tok[i+1];
   end

   assign rsp_strobe = tok[ENTRIES];

   always_comb begin
      rsp_data = '0;
      if (tok[ENTRIES]) begin
         unique case (cmd_ff.mode)
            MODE_LOOKUP: begin
               rsp_data.hit             = carry[ENTRIES].done && !own_match_ff;
               rsp_data.newly_triggered = carry[ENTRIES].newly;
            end
            MODE_ADD: begin
               rsp_data.add_rejected = !carry[ENTRIES].done;
            end
            MODE_QUERY: begin
               rsp_data.query_found = carry[ENTRIES].done;
               rsp_data.query_tag   = carry[ENTRIES].qtag;
            end
            default: begin
            end
         endcase
      end
   end

   // only one command walks the chain at a time
   assert property (@(posedge clock) disable iff (reset) $onehot0({go_ff, tok_vec}))
      else $error("more than one token in the chain");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe outside a busy command");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !busy)
      else $error("busy held after the result transfer");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> (busy && go_ff))
      else $error("accepted command did not enter the chain");

endmodule
`default_nettype wire
